@@ design/nbfe_pkg.sv @@
// Shared types and constants of the nine-bit frame exchange block.
`default_nettype none

package nbfe_pkg;

  localparam int unsigned PosW = 5;
  localparam int unsigned ByteW = 8;
  localparam logic [ByteW-1:0] ErrLimit = 8'd250;
  localparam logic [ByteW-1:0] ErrStep = 8'd2;
  localparam logic [ByteW-1:0] LatchMask = 8'h03;

  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_WR_STAGE = 3'd1,
    CMD_WR_LATCH = 3'd2,
    CMD_ARM      = 3'd3,
    CMD_RD_RX    = 3'd4,
    CMD_RD_LATCH = 3'd5,
    CMD_STATUS   = 3'd6
  } cmd_e;

  // Memory bank selectors; the three receive banks follow the fixed ones.
  localparam logic [2:0] BankStage = 3'd0;
  localparam logic [2:0] BankLatchTx = 3'd1;
  localparam logic [2:0] BankTxWork = 3'd2;
  localparam logic [2:0] BankRxBase = 3'd3;
  localparam int unsigned NumBanks = 6;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [PosW-1:0]  index;
    logic [ByteW-1:0] write_value;
    logic             rx_present;
    logic             rx_ninth;
    logic [ByteW-1:0] rx_byte;
    logic             params_complete;
    logic             latch_type_nonzero;
  } in_req_t;

  typedef struct packed {
    logic [ByteW-1:0] tx_byte;
    logic             tx_ninth_bit;
    logic             frame_done;
    logic             rx_latched;
    logic [PosW-1:0]  frame_position;
    logic [ByteW-1:0] error_count;
    logic             sync_error;
    logic [ByteW-1:0] read_value;
  } out_rsp_t;

endpackage

`default_nettype wire

@@ design/nbfe_in_if.sv @@
// Request channel interface carrying one command item.
`default_nettype none

interface nbfe_in_if;
  import nbfe_pkg::*;

  logic    valid;
  logic    ready;
  in_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ design/nbfe_out_if.sv @@
// Response channel interface carrying one result item.
`default_nettype none

interface nbfe_out_if;
  import nbfe_pkg::*;

  logic     valid;
  logic     ready;
  out_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ design/nine_bit_frame_exchange_sync.sv @@
// Master side of a nine-bit frame exchange with all frame buffers in one memory.
// A request passes through accept, read and respond states before its result is loaded.
// A tick that ends a frame also copies the transmit frame into its work bank before the read.
// One request is in flight at a time; the next one is taken while a result waits.
// The memory has a single read port; receive frames rotate among banks.
// Reset is asynchronous and active low; per-entry valid bits make every buffer read as zero.
`default_nettype none

module nine_bit_frame_exchange_sync #(
  parameter int unsigned FRAME_BYTES = 20
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  nbfe_in_if.sink     in_i,
  nbfe_out_if.source  out_o
);
  import nbfe_pkg::*;

  localparam int unsigned IdxW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned MemDepth = NumBanks * (2 ** IdxW);
  localparam int unsigned AddrW = $clog2(MemDepth);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_COPY = 4'b0010,
    S_READ = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  function automatic logic [1:0] free_ptr(logic [1:0] a, logic [1:0] b);
    logic [1:0] res;
    if (a != 2'd0 && b != 2'd0) begin
      res = 2'd0;
    end else if (a != 2'd1 && b != 2'd1) begin
      res = 2'd1;
    end else begin
      res = 2'd2;
    end
    return res;
  endfunction

  state_e state_q, state_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [ByteW-1:0] err_q, err_d;
  logic sticky_q, sticky_d;
  logic armed_q, armed_d;
  logic type_q, type_d;
  logic [1:0] rx0_lo_q, rx0_lo_d;
  logic [1:0] wptr_q, wptr_d, dptr_q, dptr_d, lptr_q, lptr_d;
  logic [2:0] src_bank_q, src_bank_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic cp_pend_q, cp_pend_d;
  logic [IdxW-1:0] cp_idx_q, cp_idx_d;
  logic [AddrW-1:0] rd_addr_q, rd_addr_d;
  logic use_tx_q, use_tx_d, use_host_q, use_host_d;
  out_rsp_t res_q, res_d;
  logic out_valid_q, out_valid_d;
  out_rsp_t out_q, out_d;

  logic [ByteW-1:0] mem_q [MemDepth];
  logic [MemDepth-1:0] vld_q;
  logic [ByteW-1:0] rdata_q;
  logic rvld_q;
  logic mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [ByteW-1:0] mem_wdata, mdata;

  in_req_t req;
  logic accept, ninth, idx_ok, frame_end, sync_err;
  logic [ByteW-1:0] rxval;
  logic [ByteW:0] err_sum;
  logic [PosW-1:0] new_pos;

  assign req = in_i.payload;
  assign in_i.ready = (state_q == S_IDLE);
  assign accept = in_i.valid && (state_q == S_IDLE);
  assign ninth = req.rx_present && req.rx_ninth;
  assign rxval = req.rx_present ? req.rx_byte : '0;
  assign idx_ok = {1'b0, req.index} < (PosW + 1)'(FRAME_BYTES);
  assign err_sum = {1'b0, err_q} + {1'b0, ErrStep};
  assign mdata = rvld_q ? rdata_q : '0;

  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_q;

  always_comb begin
    state_d = state_q;
    pos_d = pos_q;
    err_d = err_q;
    sticky_d = sticky_q;
    armed_d = armed_q;
    type_d = type_q;
    rx0_lo_d = rx0_lo_q;
    wptr_d = wptr_q;
    dptr_d = dptr_q;
    lptr_d = lptr_q;
    src_bank_d = src_bank_q;
    cnt_d = cnt_q;
    cp_pend_d = 1'b0;
    cp_idx_d = cp_idx_q;
    rd_addr_d = rd_addr_q;
    use_tx_d = use_tx_q;
    use_host_d = use_host_q;
    res_d = res_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d = out_q;
    mem_we = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re = 1'b0;
    mem_raddr = rd_addr_q;
    frame_end = 1'b0;
    sync_err = 1'b0;
    new_pos = pos_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d = '0;
          use_tx_d = 1'b0;
          use_host_d = 1'b0;
          state_d = S_READ;
          case (cmd_e'(req.cmd))
            CMD_TICK: begin
              if (pos_q == '0) begin
                if (ninth) begin
                  mem_we = 1'b1;
                  mem_waddr = {BankRxBase + {1'b0, wptr_q}, pos_q[IdxW-1:0]};
                  mem_wdata = rxval;
                  rx0_lo_d = rxval[1:0] & LatchMask[1:0];
                  new_pos = PosW'(1);
                end else begin
                  sync_err = 1'b1;
                end
              end else if (!ninth) begin
                mem_we = 1'b1;
                mem_waddr = {BankRxBase + {1'b0, wptr_q}, pos_q[IdxW-1:0]};
                mem_wdata = rxval;
                frame_end = (pos_q == PosW'(FRAME_BYTES - 1));
                new_pos = frame_end ? '0 : pos_q + PosW'(1);
                if (err_q != '0) begin
                  err_d = err_q - 8'd1;
                end
              end else begin
                new_pos = '0;
                sync_err = 1'b1;
              end
              if (sync_err) begin
                if (req.params_complete) begin
                  if (err_sum > {1'b0, ErrLimit}) begin
                    sticky_d = 1'b1;
                    err_d = ErrLimit;
                  end else begin
                    err_d = err_sum[ByteW-1:0];
                  end
                end else begin
                  err_d = '0;
                end
              end
              if (frame_end) begin
                if (armed_q && type_q) begin
                  armed_d = 1'b0;
                  src_bank_d = BankLatchTx;
                end else begin
                  src_bank_d = BankStage;
                end
                dptr_d = wptr_q;
                lptr_d = (rx0_lo_q != '0) ? wptr_q : lptr_q;
                wptr_d = free_ptr(wptr_q, (rx0_lo_q != '0) ? wptr_q : lptr_q);
                res_d.frame_done = 1'b1;
                res_d.rx_latched = (rx0_lo_q != '0);
                cnt_d = '0;
                state_d = S_COPY;
              end
              pos_d = new_pos;
              res_d.tx_ninth_bit = (new_pos == '0);
              rd_addr_d = {BankTxWork, new_pos[IdxW-1:0]};
              use_tx_d = 1'b1;
            end
            CMD_WR_STAGE, CMD_WR_LATCH: begin
              mem_we = idx_ok;
              mem_waddr = {(cmd_e'(req.cmd) == CMD_WR_STAGE) ? BankStage : BankLatchTx,
                           req.index[IdxW-1:0]};
              mem_wdata = req.write_value;
            end
            CMD_ARM: begin
              armed_d = 1'b1;
              type_d = req.latch_type_nonzero;
            end
            CMD_RD_RX, CMD_RD_LATCH: begin
              use_host_d = idx_ok;
              rd_addr_d = {BankRxBase + {1'b0, (cmd_e'(req.cmd) == CMD_RD_RX) ? dptr_q : lptr_q},
                           req.index[IdxW-1:0]};
            end
            default: begin
            end
          endcase
        end
      end
      S_COPY: begin
        if (cp_pend_q) begin
          mem_we = 1'b1;
          mem_waddr = {BankTxWork, cp_idx_q};
          mem_wdata = mdata;
        end
        if (cnt_q != CntW'(FRAME_BYTES)) begin
          mem_re = 1'b1;
          mem_raddr = {src_bank_q, cnt_q[IdxW-1:0]};
          cp_pend_d = 1'b1;
          cp_idx_d = cnt_q[IdxW-1:0];
          cnt_d = cnt_q + CntW'(1);
        end else if (!cp_pend_q) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        mem_re = 1'b1;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_d = res_q;
          out_d.tx_byte = use_tx_q ? mdata : '0;
          out_d.read_value = use_host_q ? mdata : '0;
          out_d.frame_position = pos_q;
          out_d.error_count = err_q;
          out_d.sync_error = sticky_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[mem_waddr] <= 1'b1;
      end
      if (mem_re) begin
        rvld_q <= vld_q[mem_raddr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pos_q <= PosW'(FRAME_BYTES - 1);
      err_q <= '0;
      sticky_q <= 1'b0;
      armed_q <= 1'b0;
      type_q <= 1'b0;
      rx0_lo_q <= '0;
      wptr_q <= 2'd0;
      dptr_q <= 2'd1;
      lptr_q <= 2'd2;
      cp_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q <= pos_d;
      err_q <= err_d;
      sticky_q <= sticky_d;
      armed_q <= armed_d;
      type_q <= type_d;
      rx0_lo_q <= rx0_lo_d;
      wptr_q <= wptr_d;
      dptr_q <= dptr_d;
      lptr_q <= lptr_d;
      cp_pend_q <= cp_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_bank_q <= src_bank_d;
    cnt_q <= cnt_d;
    cp_idx_q <= cp_idx_d;
    rd_addr_q <= rd_addr_d;
    use_tx_q <= use_tx_d;
    use_host_q <= use_host_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  a_err_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q <= ErrLimit)
    else $error("error counter above its limit");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_q} < (PosW + 1)'(FRAME_BYTES))
    else $error("frame position out of range");

  a_sticky_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sticky_q |=> sticky_q)
    else $error("sync error flag cleared without reset");

  a_work_bank_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wptr_q != dptr_q && wptr_q != lptr_q && wptr_q <= 2'd2)
    else $error("receive work bank shared with a delivered frame");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COPY) |=> !cp_pend_q || (state_q == S_COPY))
    else $error("copy left with a write pending");

endmodule

`default_nettype wire

@@ bench/tb_nine_bit_frame_exchange_sync.sv @@
// Self-checking testbench for the nine-bit frame exchange block.
`default_nettype none

module tb_nine_bit_frame_exchange_sync;
  timeunit 1ns;
  timeprecision 1ps;

  import nbfe_pkg::*;

  localparam int unsigned FRAME_BYTES = 20;
  localparam int unsigned NUM_ITEMS = 1750;
  localparam int unsigned CALM_FROM = 1450;
  localparam int unsigned STORM_AT = 600;
  localparam int unsigned STORM_LEN = 130;
  localparam int unsigned MAX_INDEX = (1 << PosW) - 1;
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  class exchange_scoreboard;
    logic [PosW-1:0]  pos;
    logic [ByteW-1:0] err_cnt;
    logic             err_flag;
    logic             armed;
    logic             armed_type;
    logic [ByteW-1:0] rx_work [FRAME_BYTES];
    logic [ByteW-1:0] tx_work [FRAME_BYTES];
    logic [ByteW-1:0] staging [FRAME_BYTES];
    logic [ByteW-1:0] latch_tx [FRAME_BYTES];
    logic [ByteW-1:0] rx_frame [FRAME_BYTES];
    logic [ByteW-1:0] latch_rx [FRAME_BYTES];
    out_rsp_t         expected_rsp [$];
    int               mismatches;

    function new();
      pos = PosW'(FRAME_BYTES - 1);
      err_cnt = '0;
      err_flag = 1'b0;
      armed = 1'b0;
      armed_type = 1'b0;
      mismatches = 0;
      foreach (rx_work[i]) begin
        rx_work[i] = '0;
        tx_work[i] = '0;
        staging[i] = '0;
        latch_tx[i] = '0;
        rx_frame[i] = '0;
        latch_rx[i] = '0;
      end
    endfunction

    function void count_sync_error(logic enabled);
      int unsigned sum;
      if (enabled) begin
        sum = 32'(err_cnt) + 32'(ErrStep);
        if (sum > 32'(ErrLimit)) begin
          err_flag = 1'b1;
          sum = 32'(ErrLimit);
        end
        err_cnt = sum[ByteW-1:0];
      end else begin
        err_cnt = '0;
      end
    endfunction

    function void note_request(in_req_t r);
      out_rsp_t         o;
      logic             ninth;
      logic [ByteW-1:0] rx_val;
      logic             idx_ok;
      o = '0;
      ninth = r.rx_present & r.rx_ninth;
      rx_val = r.rx_present ? r.rx_byte : '0;
      idx_ok = r.index < FRAME_BYTES;
      case (r.cmd)
        CMD_TICK: begin
          if (pos == 0) begin
            if (ninth) begin
              rx_work[0] = rx_val;
              pos = PosW'(1);
            end else begin
              count_sync_error(r.params_complete);
            end
          end else if (!ninth) begin
            rx_work[pos] = rx_val;
            if (pos == FRAME_BYTES - 1) begin
              if (armed && armed_type) begin
                armed = 1'b0;
                tx_work = latch_tx;
              end else begin
                tx_work = staging;
              end
              rx_frame = rx_work;
              if ((rx_work[0] & LatchMask) != 0) begin
                latch_rx = rx_work;
                o.rx_latched = 1'b1;
              end
              o.frame_done = 1'b1;
              pos = '0;
            end else begin
              pos = pos + 1'b1;
            end
            if (err_cnt != 0) err_cnt = err_cnt - 1'b1;
          end else begin
            pos = '0;
            count_sync_error(r.params_complete);
          end
          o.tx_byte = tx_work[pos];
          o.tx_ninth_bit = (pos == 0);
        end
        CMD_WR_STAGE: if (idx_ok) staging[r.index] = r.write_value;
        CMD_WR_LATCH: if (idx_ok) latch_tx[r.index] = r.write_value;
        CMD_ARM: begin
          armed = 1'b1;
          armed_type = r.latch_type_nonzero;
        end
        CMD_RD_RX: if (idx_ok) o.read_value = rx_frame[r.index];
        CMD_RD_LATCH: if (idx_ok) o.read_value = latch_rx[r.index];
        default: ;
      endcase
      o.frame_position = pos;
      o.error_count = err_cnt;
      o.sync_error = err_flag;
      expected_rsp.push_back(o);
    endfunction

    function void check_result(out_rsp_t got);
      out_rsp_t want;
      logic     bad;
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result at %0t: pos %0d err %0d", $realtime,
                   got.frame_position, got.error_count);
        return;
      end
      want = expected_rsp.pop_front();
      bad = (got.tx_byte !== want.tx_byte) || (got.tx_ninth_bit !== want.tx_ninth_bit) ||
            (got.frame_done !== want.frame_done) || (got.rx_latched !== want.rx_latched) ||
            (got.frame_position !== want.frame_position) ||
            (got.error_count !== want.error_count) || (got.sync_error !== want.sync_error) ||
            (got.read_value !== want.read_value);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR at %0t (expected/actual): tx_byte %h/%h ninth %b/%b done %b/%b",
                   $realtime, want.tx_byte, got.tx_byte, want.tx_ninth_bit, got.tx_ninth_bit,
                   want.frame_done, got.frame_done);
          $display("  latched %b/%b pos %0d/%0d err %0d/%0d sticky %b/%b read %h/%h",
                   want.rx_latched, got.rx_latched, want.frame_position, got.frame_position,
                   want.error_count, got.error_count, want.sync_error, got.sync_error,
                   want.read_value, got.read_value);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int unsigned req_count = 0;
  logic no_idle = 1'b0;
  exchange_scoreboard sb = new();

  nbfe_in_if req_if ();
  nbfe_out_if rsp_if ();

  nine_bit_frame_exchange_sync #(.FRAME_BYTES(FRAME_BYTES)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic in_req_t noise_req();
    logic [31:0] bits;
    bits = $urandom;
    return bits[$bits(in_req_t)-1:0];
  endfunction

  function automatic logic [PosW-1:0] pick_index();
    if ($urandom_range(0, 7) == 0) return PosW'($urandom_range(FRAME_BYTES, MAX_INDEX));
    return PosW'($urandom_range(0, FRAME_BYTES - 1));
  endfunction

  task automatic send_req(input in_req_t r);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.payload <= r;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(r);
    req_count++;
  endtask

  task automatic send_tick(input logic present, input logic ninth,
                           input logic [ByteW-1:0] data, input logic params);
    in_req_t r;
    r = noise_req();
    r.cmd = CMD_TICK;
    r.rx_present = present;
    r.rx_ninth = ninth;
    r.rx_byte = data;
    r.params_complete = params;
    send_req(r);
  endtask

  task automatic send_host(input logic [2:0] code, input logic [PosW-1:0] idx,
                           input logic [ByteW-1:0] val, input logic type_nz);
    in_req_t r;
    r = noise_req();
    r.cmd = code;
    r.index = idx;
    r.write_value = val;
    r.latch_type_nonzero = type_nz;
    send_req(r);
  endtask

  task automatic random_host();
    send_host(3'($urandom_range(CMD_WR_STAGE, CMD_UNUSED)), pick_index(), 8'($urandom),
              1'($urandom));
  endtask

  task automatic good_byte();
    logic present;
    present = ($urandom_range(0, 9) != 0);
    send_tick(present, present ? 1'b0 : 1'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // Finishes the frame in progress so that the next tick starts a new one.
  task automatic align_frame();
    while (sb.pos != 0) good_byte();
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_rsp.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned pick;
    logic        storm_done;
    storm_done = 1'b0;
    rst_ni <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.payload <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_host(CMD_STATUS, '0, '0, 1'b0);
    send_host(CMD_RD_RX, '0, '0, 1'b0);
    send_host(CMD_RD_LATCH, PosW'(MAX_INDEX), '0, 1'b0);
    send_host(CMD_UNUSED, PosW'(MAX_INDEX), 8'hFF, 1'b1);
    send_tick(1'b0, 1'b1, 8'hFF, 1'b1);
    send_tick(1'b1, 1'b0, 8'h00, 1'b1);
    send_tick(1'b1, 1'b0, 8'hFF, 1'b0);
    send_tick(1'b1, 1'b0, 8'h00, 1'b1);
    send_tick(1'b1, 1'b1, 8'hFF, 1'b0);
    send_tick(1'b1, 1'b1, 8'h00, 1'b1);
    send_tick(1'b0, 1'b1, 8'hFF, 1'b1);
    send_tick(1'b1, 1'b1, 8'h03, 1'b0);
    send_tick(1'b1, 1'b0, 8'hFF, 1'b0);
    send_host(CMD_WR_STAGE, '0, 8'hFF, 1'b0);
    send_host(CMD_WR_STAGE, PosW'(FRAME_BYTES - 1), 8'h00, 1'b0);
    send_host(CMD_WR_STAGE, PosW'(FRAME_BYTES), 8'hAA, 1'b0);
    send_host(CMD_WR_STAGE, PosW'(MAX_INDEX), 8'h55, 1'b0);
    send_host(CMD_WR_LATCH, '0, 8'h5A, 1'b0);
    send_host(CMD_WR_LATCH, PosW'(FRAME_BYTES - 1), 8'hA5, 1'b0);
    send_host(CMD_WR_LATCH, PosW'(MAX_INDEX), 8'hFF, 1'b0);
    send_host(CMD_ARM, '0, '0, 1'b0);
    send_host(CMD_ARM, '0, '0, 1'b1);
    send_host(CMD_RD_RX, PosW'(FRAME_BYTES - 1), '0, 1'b0);
    send_host(CMD_RD_LATCH, '0, '0, 1'b0);

    while (req_count < NUM_ITEMS) begin
      no_idle = (req_count >= CALM_FROM);
      if (!storm_done && req_count >= STORM_AT) begin
        storm_done = 1'b1;
        wait_drained();
        align_frame();
        repeat (STORM_LEN) send_tick(1'b1, 1'b0, 8'($urandom), 1'b1);
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        align_frame();
        send_tick(1'b1, 1'b1, 8'($urandom), 1'($urandom));
        repeat (FRAME_BYTES - 1) begin
          if ($urandom_range(0, 5) == 0) random_host();
          good_byte();
        end
      end else if (pick < 70) begin
        align_frame();
        send_tick(1'b1, 1'b1, 8'($urandom), 1'($urandom));
        repeat ($urandom_range(0, FRAME_BYTES - 3)) good_byte();
        send_tick(1'b1, 1'b1, 8'($urandom), ($urandom_range(0, 3) != 0));
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 6)) random_host();
      end else begin
        repeat ($urandom_range(1, 12)) begin
          send_tick(1'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
        end
      end
    end

    wait_drained();
    repeat (FRAME_BYTES + 8) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    int stall;
    stall = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.payload);
      if (stall > 0) begin
        stall--;
        rsp_if.ready <= (stall == 0);
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 4);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
